>>> rtl/ack_window_send_queue_assert.svh
// assertion macros for the send queue
`ifndef ACK_WINDOW_SEND_QUEUE_ASSERT_SVH
`define ACK_WINDOW_SEND_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define AWSQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("send queue check failed");
`define AWSQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("send queue check failed");
`else
`define AWSQ_ASSERT(lbl, prop)
`define AWSQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/acwsq_pkg.sv
package acwsq_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP        = 2'd2,
    ACT_ACK        = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_NO_SEND     = 3'd3,
    ST_UNMATCHED   = 3'd4,
    ST_UNKNOWN_ACK = 3'd5
  } status_e;

  localparam logic [1:0] KIND_PLAIN   = 2'd0;
  localparam logic [1:0] KIND_INTERIM = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;
  localparam logic [1:0] KIND_BAD     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_ACK_RD,
    S_ACK_CHK,
    S_FINISH
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    cap;
    logic    push;
    logic    q_rd;
    logic    q_rd_nxt;
    logic    q_mv_wr;
    logic    inc_idx;
    logic    deliver;
    logic    deliver_win;
    logic    pop_head;
    logic    dec_fill;
    logic    set_status;
    status_e status;
    logic    w_rd;
    logic    ack_hit;
    logic    finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    action_e act;
    logic    q_full;
    logic    q_empty;
    logic    ackable;
    logic    w_full;
    logic    scan_last;
    logic    move_last;
    logic    w_none;
    logic    w_last;
    logic    tid_match;
    logic    kin_unknown;
    logic    kind_hit;
    logic    out_free;
  } sts_t;

endpackage

>>> rtl/acwsq_ram.sv
module acwsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/acwsq_ctrl.sv
module acwsq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  acwsq_pkg::sts_t sts_i,
  output acwsq_pkg::cmd_t cmd_o
);

  acwsq_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acwsq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = acwsq_pkg::ST_OK;
    in_stall_o = 1'b1;
    unique case (state_q)
      acwsq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = acwsq_pkg::S_DISPATCH;
        end
      end
      acwsq_pkg::S_DISPATCH: begin
        unique case (sts_i.act)
          acwsq_pkg::ACT_PUSH_BACK, acwsq_pkg::ACT_PUSH_FRONT: begin
            if (sts_i.q_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = acwsq_pkg::ST_FULL;
            end else begin
              cmd_o.push = 1'b1;
            end
            state_d = acwsq_pkg::S_FINISH;
          end
          acwsq_pkg::ACT_POP: begin
            if (sts_i.q_empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = acwsq_pkg::ST_EMPTY;
              state_d          = acwsq_pkg::S_FINISH;
            end else begin
              cmd_o.q_rd = 1'b1;
              state_d    = acwsq_pkg::S_POP_CHK;
            end
          end
          acwsq_pkg::ACT_ACK: begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = acwsq_pkg::ST_UNMATCHED;
            if (sts_i.w_none) begin
              state_d = acwsq_pkg::S_FINISH;
            end else begin
              cmd_o.w_rd = 1'b1;
              state_d    = acwsq_pkg::S_ACK_CHK;
            end
          end
          default: state_d = acwsq_pkg::S_FINISH;
        endcase
      end
      // head item is in the read register
      acwsq_pkg::S_POP_CHK: begin
        if (!sts_i.ackable) begin
          cmd_o.deliver  = 1'b1;
          cmd_o.pop_head = 1'b1;
          state_d        = acwsq_pkg::S_FINISH;
        end else if (!sts_i.w_full) begin
          cmd_o.deliver     = 1'b1;
          cmd_o.deliver_win = 1'b1;
          cmd_o.pop_head    = 1'b1;
          state_d           = acwsq_pkg::S_FINISH;
        end else begin
          state_d = acwsq_pkg::S_SCAN_CHK;
        end
      end
      acwsq_pkg::S_SCAN_RD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = acwsq_pkg::S_SCAN_CHK;
      end
      // look for the first plain item
      acwsq_pkg::S_SCAN_CHK: begin
        if (!sts_i.ackable) begin
          cmd_o.deliver = 1'b1;
          if (sts_i.scan_last) begin
            cmd_o.dec_fill = 1'b1;
            state_d        = acwsq_pkg::S_FINISH;
          end else begin
            state_d = acwsq_pkg::S_MOVE_RD;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
          if (sts_i.scan_last) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = acwsq_pkg::ST_NO_SEND;
            state_d          = acwsq_pkg::S_FINISH;
          end else begin
            state_d = acwsq_pkg::S_SCAN_RD;
          end
        end
      end
      // close up the queue one item at a time: read it, then write it one slot nearer the head
      acwsq_pkg::S_MOVE_RD: begin
        cmd_o.q_rd_nxt = 1'b1;
        state_d        = acwsq_pkg::S_MOVE_WR;
      end
      acwsq_pkg::S_MOVE_WR: begin
        cmd_o.q_mv_wr = 1'b1;
        cmd_o.inc_idx = 1'b1;
        if (sts_i.move_last) begin
          cmd_o.dec_fill = 1'b1;
          state_d        = acwsq_pkg::S_FINISH;
        end else begin
          state_d = acwsq_pkg::S_MOVE_RD;
        end
      end
      acwsq_pkg::S_ACK_RD: begin
        cmd_o.w_rd = 1'b1;
        state_d    = acwsq_pkg::S_ACK_CHK;
      end
      // match ack against one window entry
      acwsq_pkg::S_ACK_CHK: begin
        if (sts_i.tid_match && sts_i.kin_unknown) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = acwsq_pkg::ST_UNKNOWN_ACK;
          state_d          = acwsq_pkg::S_FINISH;
        end else if (sts_i.tid_match && sts_i.kind_hit) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = acwsq_pkg::ST_OK;
          cmd_o.ack_hit    = 1'b1;
          state_d          = acwsq_pkg::S_FINISH;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d = sts_i.w_last ? acwsq_pkg::S_FINISH : acwsq_pkg::S_ACK_RD;
        end
      end
      acwsq_pkg::S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = acwsq_pkg::S_IDLE;
        end
      end
      default: state_d = acwsq_pkg::S_IDLE;
    endcase
  end

endmodule

>>> rtl/acwsq_dp.sv
module acwsq_dp #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int WINDOW_SIZE   = 8,
  parameter int TABLE_ID_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  acwsq_pkg::cmd_t                  cmd_i,
  output acwsq_pkg::sts_t                  sts_o,
  input  logic [1:0]                       action_i,
  input  logic [31:0]                      data_handle_i,
  input  logic [15:0]                      table_id_i,
  input  logic [1:0]                       kind_code_i,
  input  logic [7:0]                       priority_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             item_valid_o,
  output logic [31:0]                      out_data_handle_o,
  output logic [15:0]                      out_table_id_o,
  output logic [1:0]                       out_kind_o,
  output logic [7:0]                       out_priority_o,
  output logic                             awaits_ack_o,
  output logic [2:0]                       status_o,
  output logic                             window_cleared_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count_o
);

  localparam int TIDW = (TABLE_ID_BITS < 16) ? TABLE_ID_BITS : 16;
  localparam int QAW  = $clog2(QUEUE_DEPTH);
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int WAW  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int WCW  = $clog2(WINDOW_SIZE + 1);
  localparam int IW   = (QCW > WCW) ? QCW : WCW;
  localparam int QW   = 32 + TIDW + 2 + 8;
  localparam int WW   = TIDW + 2;

  // captured request
  acwsq_pkg::action_e act_q;
  logic [31:0]        data_q;
  logic [TIDW-1:0]    tid_q;
  logic [1:0]         kin_q;
  logic [7:0]         prio_q;

  // queue and window bookkeeping
  logic [QAW-1:0]         head_q;
  logic [QCW-1:0]         qfill_q;
  logic [WCW-1:0]         wfill_q;
  logic [WCW-1:0]         atot_q;
  logic [WINDOW_SIZE-1:0] acked_q;
  logic [IW-1:0]          idx_q;

  // result being built
  logic          rvalid_q, rawait_q, rclr_q;
  logic [31:0]   rdata_q;
  logic [TIDW-1:0] rtid_q;
  logic [1:0]    rkind_q;
  logic [7:0]    rprio_q;
  acwsq_pkg::status_e rstat_q;

  // output register
  logic          ovalid_q, oitem_q, oawait_q, oclr_q;
  logic [31:0]   odata_q;
  logic [TIDW-1:0] otid_q;
  logic [1:0]    okind_q;
  logic [7:0]    oprio_q;
  logic [2:0]    ostat_q;
  logic [QCW-1:0] ocount_q;

  // memory ports
  logic [QW-1:0]  q_rdata, q_wdata;
  logic [QAW-1:0] q_raddr, q_waddr, head_dec, head_inc;
  logic           q_we;
  logic [WW-1:0]  w_rdata;
  logic [TIDW-1:0] h_tid, w_tid;
  logic [1:0]     h_kind, w_kind;
  logic [1:0]     push_kind;
  logic [IW:0]    off_rd, off_wr, sum_rd, sum_wr;
  logic [IW:0]    idx_ext, qfill_ext;
  logic           clear_win;

  assign idx_ext   = {1'b0, idx_q};
  assign qfill_ext = (IW + 1)'(qfill_q);

  // ring slot from head and offset
  assign off_rd = cmd_i.q_rd_nxt ? idx_ext + (IW + 1)'(1) : idx_ext;
  assign off_wr = cmd_i.push ? qfill_ext : idx_ext;
  assign sum_rd = (IW + 1)'(head_q) + off_rd;
  assign sum_wr = (IW + 1)'(head_q) + off_wr;
  assign q_raddr = (sum_rd >= (IW + 1)'(QUEUE_DEPTH)) ?
                   QAW'(sum_rd - (IW + 1)'(QUEUE_DEPTH)) : QAW'(sum_rd);
  assign head_dec = (head_q == '0) ? QAW'(QUEUE_DEPTH - 1) : head_q - QAW'(1);
  assign head_inc = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);

  // queue write: push back, push front or close-up move
  assign push_kind = (kin_q == acwsq_pkg::KIND_BAD) ? acwsq_pkg::KIND_PLAIN : kin_q;
  always_comb begin
    q_waddr = (sum_wr >= (IW + 1)'(QUEUE_DEPTH)) ?
              QAW'(sum_wr - (IW + 1)'(QUEUE_DEPTH)) : QAW'(sum_wr);
    q_wdata = q_rdata;
    if (cmd_i.push) begin
      q_wdata = {data_q, tid_q, push_kind, prio_q};
      if (act_q == acwsq_pkg::ACT_PUSH_FRONT) begin
        q_waddr = head_dec;
      end
    end
  end
  assign q_we = cmd_i.push | cmd_i.q_mv_wr;

  acwsq_ram #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (cmd_i.q_rd | cmd_i.q_rd_nxt),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign h_tid  = q_rdata[TIDW+9:10];
  assign h_kind = q_rdata[9:8];

  acwsq_ram #(.WIDTH(WW), .DEPTH(WINDOW_SIZE)) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.deliver_win),
    .waddr_i (wfill_q[WAW-1:0]),
    .wdata_i ({h_tid, h_kind}),
    .re_i    (cmd_i.w_rd),
    .raddr_i (idx_q[WAW-1:0]),
    .rdata_o (w_rdata)
  );

  assign w_tid  = w_rdata[WW-1:2];
  assign w_kind = w_rdata[1:0];

  assign clear_win = ({1'b0, atot_q} + (WCW + 1)'(1)) >= (WCW + 1)'(WINDOW_SIZE);

  // status to controller
  always_comb begin
    sts_o.act       = act_q;
    sts_o.q_full    = qfill_q >= QCW'(QUEUE_DEPTH);
    sts_o.q_empty   = qfill_q == '0;
    sts_o.ackable   = (h_kind == acwsq_pkg::KIND_INTERIM) ||
                      (h_kind == acwsq_pkg::KIND_FINAL);
    sts_o.w_full    = wfill_q >= WCW'(WINDOW_SIZE);
    sts_o.scan_last = (idx_ext + (IW + 1)'(1)) >= qfill_ext;
    sts_o.move_last = (idx_ext + (IW + 1)'(2)) >= qfill_ext;
    sts_o.w_none    = wfill_q == '0;
    sts_o.w_last    = (idx_ext + (IW + 1)'(1)) >= (IW + 1)'(wfill_q);
    sts_o.tid_match = w_tid == tid_q;
    sts_o.kin_unknown = kin_q[1];
    sts_o.kind_hit  = (w_kind == kin_q + 2'd1) && !acked_q[idx_q[WAW-1:0]];
    sts_o.out_free  = !ovalid_q || !out_stall_i;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      act_q  <= acwsq_pkg::action_e'(action_i);
      data_q <= data_handle_i;
      tid_q  <= table_id_i[TIDW-1:0];
      kin_q  <= kind_code_i;
      prio_q <= priority_req_i;
    end
  end

  // queue and window counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      qfill_q <= '0;
      wfill_q <= '0;
      atot_q  <= '0;
      acked_q <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.cap) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.push) begin
        qfill_q <= qfill_q + QCW'(1);
        if (act_q == acwsq_pkg::ACT_PUSH_FRONT) begin
          head_q <= head_dec;
        end
      end else if (cmd_i.pop_head) begin
        qfill_q <= qfill_q - QCW'(1);
        head_q  <= head_inc;
      end else if (cmd_i.dec_fill) begin
        qfill_q <= qfill_q - QCW'(1);
      end
      if (cmd_i.deliver_win) begin
        wfill_q <= wfill_q + WCW'(1);
        acked_q[wfill_q[WAW-1:0]] <= 1'b0;
      end else if (cmd_i.ack_hit) begin
        if (clear_win) begin
          wfill_q <= '0;
          atot_q  <= '0;
          acked_q <= '0;
        end else begin
          atot_q <= atot_q + WCW'(1);
          acked_q[idx_q[WAW-1:0]] <= 1'b1;
        end
      end
    end
  end

  // result build-up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      rawait_q <= 1'b0;
      rclr_q   <= 1'b0;
      rstat_q  <= acwsq_pkg::ST_OK;
    end else begin
      if (cmd_i.cap) begin
        rvalid_q <= 1'b0;
        rawait_q <= 1'b0;
        rclr_q   <= 1'b0;
        rstat_q  <= acwsq_pkg::ST_OK;
      end
      if (cmd_i.set_status) begin
        rstat_q <= cmd_i.status;
      end
      if (cmd_i.deliver) begin
        rvalid_q <= 1'b1;
      end
      if (cmd_i.deliver_win) begin
        rawait_q <= 1'b1;
      end
      if (cmd_i.ack_hit && clear_win) begin
        rclr_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.deliver) begin
      rdata_q <= q_rdata[QW-1 -: 32];
      rtid_q  <= h_tid;
      rkind_q <= h_kind;
      rprio_q <= q_rdata[7:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      oitem_q  <= rvalid_q;
      odata_q  <= rvalid_q ? rdata_q : '0;
      otid_q   <= rvalid_q ? rtid_q : '0;
      okind_q  <= rvalid_q ? rkind_q : '0;
      oprio_q  <= rvalid_q ? rprio_q : '0;
      oawait_q <= rawait_q;
      ostat_q  <= rstat_q;
      oclr_q   <= rclr_q;
      ocount_q <= qfill_q;
    end
  end

  assign out_valid_o       = ovalid_q;
  assign item_valid_o      = oitem_q;
  assign out_data_handle_o = odata_q;
  assign out_table_id_o    = 16'(otid_q);
  assign out_kind_o        = okind_q;
  assign out_priority_o    = oprio_q;
  assign awaits_ack_o      = oawait_q;
  assign status_o          = ostat_q;
  assign window_cleared_o  = oclr_q;
  assign queue_count_o     = ocount_q;

endmodule

>>> rtl/ack_window_send_queue.sv
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   action, data_handle, table_id, kind_code,
//                                               priority_req
// out      output     out_valid_o / out_stall_i item_valid .. queue_count
//
// push: capture, dispatch, finish; pop of head: read, check, finish; pop with full window
// scans the queue item by item and closes it up by moving each later item one slot nearer
// the head; ack: straight to finish with an empty window, else entries are checked in turn.
// The registered read of the queue memory sets the scan and move pace.
// Reset clears all counters and ack bits; no clearing pass. An out stall holds the
// result; the next item may start but waits before finishing until there is room.
`include "ack_window_send_queue_assert.svh"

module ack_window_send_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int WINDOW_SIZE   = 8,
  parameter int TABLE_ID_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       action_i,
  input  logic [31:0]                      data_handle_i,
  input  logic [15:0]                      table_id_i,
  input  logic [1:0]                       kind_code_i,
  input  logic [7:0]                       priority_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             item_valid_o,
  output logic [31:0]                      out_data_handle_o,
  output logic [15:0]                      out_table_id_o,
  output logic [1:0]                       out_kind_o,
  output logic [7:0]                       out_priority_o,
  output logic                             awaits_ack_o,
  output logic [2:0]                       status_o,
  output logic                             window_cleared_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count_o
);

  acwsq_pkg::cmd_t cmd;
  acwsq_pkg::sts_t sts;

  acwsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  acwsq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .WINDOW_SIZE   (WINDOW_SIZE),
    .TABLE_ID_BITS (TABLE_ID_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .action_i          (action_i),
    .data_handle_i     (data_handle_i),
    .table_id_i        (table_id_i),
    .kind_code_i       (kind_code_i),
    .priority_req_i    (priority_req_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .item_valid_o      (item_valid_o),
    .out_data_handle_o (out_data_handle_o),
    .out_table_id_o    (out_table_id_o),
    .out_kind_o        (out_kind_o),
    .out_priority_o    (out_priority_o),
    .awaits_ack_o      (awaits_ack_o),
    .status_o          (status_o),
    .window_cleared_o  (window_cleared_o),
    .queue_count_o     (queue_count_o)
  );

  // checks
  `AWSQ_ASSERT(busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `AWSQ_ASSERT(item_means_ok, (out_valid_o && item_valid_o) |-> (status_o == acwsq_pkg::ST_OK))
  `AWSQ_ASSERT(await_needs_item, (out_valid_o && awaits_ack_o) |-> item_valid_o)
  `AWSQ_ASSERT(count_bounded, out_valid_o |-> (queue_count_o <= QUEUE_DEPTH))

endmodule

>>> tb/ack_window_send_queue_test.sv
`timescale 1ns / 1ps

module ack_window_send_queue_test;

  localparam int QDEPTH = 16;
  localparam int WSIZE  = 8;

  // one send queue descriptor
  typedef struct {
    logic [31:0] data;
    logic [15:0] tid;
    logic [1:0]  kind;
    logic [7:0]  prio;
  } desc_t;

  // one delivered result
  typedef struct {
    logic        item_valid;
    logic [31:0] data;
    logic [15:0] tid;
    logic [1:0]  kind;
    logic [7:0]  prio;
    logic        awaits;
    logic [2:0]  status;
    logic        cleared;
    logic [4:0]  count;
  } result_t;

  // predicts queue and window behavior and checks delivered results
  class send_queue_scoreboard;
    desc_t       q[$];
    logic [15:0] win_tid[WSIZE];
    logic [1:0]  win_kind[WSIZE];
    bit          win_acked[WSIZE];
    int          win_fill;
    int          acked_cnt;
    result_t     pending[$];
    int          errors;

    function new();
      win_fill = 0;
      acked_cnt = 0;
      errors = 0;
    endfunction

    function void note_item(acwsq_pkg::action_e act, logic [31:0] dh, logic [15:0] tid,
                            logic [1:0] kin, logic [7:0] pr);
      result_t r;
      desc_t   d;
      r = '{default: 0};
      case (act)
        acwsq_pkg::ACT_PUSH_BACK, acwsq_pkg::ACT_PUSH_FRONT: begin
          if (q.size() >= QDEPTH) begin
            r.status = acwsq_pkg::ST_FULL;
          end else begin
            d.data = dh;
            d.tid = tid;
            d.kind = (kin == acwsq_pkg::KIND_BAD) ? acwsq_pkg::KIND_PLAIN : kin;
            d.prio = pr;
            if (act == acwsq_pkg::ACT_PUSH_BACK) q.insert(q.size(), d);
            else q.insert(0, d);
          end
        end
        acwsq_pkg::ACT_POP: begin
          if (q.size() == 0) begin
            r.status = acwsq_pkg::ST_EMPTY;
          end else if (q[0].kind == acwsq_pkg::KIND_PLAIN || win_fill < WSIZE) begin
            d = q[0];
            q.delete(0);
            r.item_valid = 1;
            r.data = d.data; r.tid = d.tid; r.kind = d.kind; r.prio = d.prio;
            if (d.kind != acwsq_pkg::KIND_PLAIN) begin
              r.awaits = 1;
              win_tid[win_fill] = d.tid;
              win_kind[win_fill] = d.kind;
              win_acked[win_fill] = 0;
              win_fill++;
            end
          end else begin
            // window full: first plain item anywhere leaves the queue
            r.status = acwsq_pkg::ST_NO_SEND;
            foreach (q[i]) begin
              if (q[i].kind == acwsq_pkg::KIND_PLAIN) begin
                d = q[i];
                q.delete(i);
                r.item_valid = 1;
                r.status = acwsq_pkg::ST_OK;
                r.data = d.data; r.tid = d.tid; r.kind = d.kind; r.prio = d.prio;
                break;
              end
            end
          end
        end
        default: begin
          r.status = acwsq_pkg::ST_UNMATCHED;
          for (int i = 0; i < win_fill; i++) begin
            if (win_tid[i] != tid) continue;
            if (kin > 1) begin
              r.status = acwsq_pkg::ST_UNKNOWN_ACK;
              break;
            end
            if (win_kind[i] == kin + 2'd1 && !win_acked[i]) begin
              win_acked[i] = 1;
              acked_cnt++;
              r.status = acwsq_pkg::ST_OK;
              if (acked_cnt >= WSIZE) begin
                win_acked = '{default: 0};
                win_fill = 0;
                acked_cnt = 0;
                r.cleared = 1;
              end
              break;
            end
          end
        end
      endcase
      r.count = 5'(q.size());
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(result_t a);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (a.item_valid !== e.item_valid) begin
        $error("item_valid exp %0h got %0h", e.item_valid, a.item_valid); errors++;
      end
      if (a.data !== e.data) begin
        $error("out_data_handle exp %0h got %0h", e.data, a.data); errors++;
      end
      if (a.tid !== e.tid) begin
        $error("out_table_id exp %0h got %0h", e.tid, a.tid); errors++;
      end
      if (a.kind !== e.kind) begin
        $error("out_kind exp %0h got %0h", e.kind, a.kind); errors++;
      end
      if (a.prio !== e.prio) begin
        $error("out_priority exp %0h got %0h", e.prio, a.prio); errors++;
      end
      if (a.awaits !== e.awaits) begin
        $error("awaits_ack exp %0h got %0h", e.awaits, a.awaits); errors++;
      end
      if (a.status !== e.status) begin
        $error("status exp %0h got %0h", e.status, a.status); errors++;
      end
      if (a.cleared !== e.cleared) begin
        $error("window_cleared exp %0h got %0h", e.cleared, a.cleared); errors++;
      end
      if (a.count !== e.count) begin
        $error("queue_count exp %0h got %0h", e.count, a.count); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [31:0] data_handle_i = '0;
  logic [15:0] table_id_i = '0;
  logic [1:0]  kind_code_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        item_valid_o;
  logic [31:0] out_data_handle_o;
  logic [15:0] out_table_id_o;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_priority_o;
  logic        awaits_ack_o;
  logic [2:0]  status_o;
  logic        window_cleared_o;
  logic [4:0]  queue_count_o;

  send_queue_scoreboard sb = new();
  bit stim_done = 0;
  logic [15:0] tid_pool[4] = '{16'h0000, 16'hffff, 16'h1234, 16'h00a5};

  ack_window_send_queue uut (.*);

  // clock
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // pick a gap: mostly short, sometimes long, often none
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // present one item and hold it until taken
  task automatic send_item(acwsq_pkg::action_e act, logic [31:0] dh, logic [15:0] tid,
                           logic [1:0] kin, logic [7:0] pr);
    in_valid_i <= 1;
    action_i <= act;
    data_handle_i <= dh;
    table_id_i <= tid;
    kind_code_i <= kin;
    priority_req_i <= pr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(act, dh, tid, kin, pr);
    @(negedge clk_i);
  endtask

  task automatic send_gapped(acwsq_pkg::action_e act, logic [31:0] dh, logic [15:0] tid,
                             logic [1:0] kin, logic [7:0] pr);
    int g;
    send_item(act, dh, tid, kin, pr);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // random item biased toward well-formed traffic over a small table id set
  task automatic send_random();
    acwsq_pkg::action_e act;
    logic [15:0]        tid;
    int                 p;
    p = $urandom_range(99);
    if (p < 35) act = acwsq_pkg::ACT_PUSH_BACK;
    else if (p < 45) act = acwsq_pkg::ACT_PUSH_FRONT;
    else if (p < 75) act = acwsq_pkg::ACT_POP;
    else act = acwsq_pkg::ACT_ACK;
    tid = ($urandom_range(9) == 0) ? 16'($urandom) : tid_pool[$urandom_range(3)];
    send_gapped(act, $urandom, tid, ($urandom_range(7) == 0) ? 2'($urandom)
                : 2'($urandom_range(2)), 8'($urandom));
  endtask

  // output sampling
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{item_valid_o, out_data_handle_o, out_table_id_o, out_kind_o,
                        out_priority_o, awaits_ack_o, status_o, window_cleared_o,
                        queue_count_o});
  end

  // receiver stalls
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        out_stall_i <= 1;
        repeat (g) @(negedge clk_i);
        out_stall_i <= 0;
      end else begin
        repeat ($urandom_range(20)) @(negedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: empty pop, unmatched ack, fill to full, overflow
    send_item(acwsq_pkg::ACT_POP, '0, '0, acwsq_pkg::KIND_PLAIN, '0);
    send_item(acwsq_pkg::ACT_ACK, '0, 16'h1234, 2'd0, '0);
    send_item(acwsq_pkg::ACT_PUSH_BACK, 32'hffffffff, 16'hffff, acwsq_pkg::KIND_BAD, 8'hff);
    for (int i = 0; i < 8; i++)
      send_item(acwsq_pkg::ACT_PUSH_BACK, 32'(i), 16'h1234, acwsq_pkg::KIND_INTERIM, 8'(i));
    send_item(acwsq_pkg::ACT_PUSH_FRONT, 32'h0, 16'h0, acwsq_pkg::KIND_FINAL, 8'h0);
    for (int i = 0; i < 6; i++)
      send_item(acwsq_pkg::ACT_PUSH_BACK, 32'h100 + 32'(i), 16'h0, acwsq_pkg::KIND_PLAIN,
                8'h80);
    send_item(acwsq_pkg::ACT_PUSH_FRONT, '1, '1, acwsq_pkg::KIND_PLAIN, '1);
    // pops fill the window, then full-window pops take plain items
    for (int i = 0; i < 12; i++)
      send_item(acwsq_pkg::ACT_POP, '0, '0, acwsq_pkg::KIND_PLAIN, '0);
    send_item(acwsq_pkg::ACT_ACK, '0, 16'h1234, 2'd3, '0);
    send_item(acwsq_pkg::ACT_ACK, '0, 16'h0, 2'd0, '0);
    send_item(acwsq_pkg::ACT_ACK, '0, 16'h0, 2'd1, '0);
    for (int i = 0; i < 8; i++)
      send_item(acwsq_pkg::ACT_ACK, '0, 16'h1234, 2'd0, '0);
    for (int i = 0; i < 1250; i++)
      send_random();
    in_valid_i <= 0;
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0)
      $display("ack_window_send_queue_test passed");
    else
      $display("ack_window_send_queue_test failed");
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("ack_window_send_queue_test failed");
    $finish;
  end

endmodule
